// ===== rtl/core/fqe_pkg.sv =====
// package for the form query url encoder: item types, op and kind codes,
// character constants and the byte classification helpers
// no dependencies
package fqe_pkg;

    // op codes of an input item
    localparam logic [2:0] OP_BEGIN  = 3'd0;
    localparam logic [2:0] OP_FIELD  = 3'd1;
    localparam logic [2:0] OP_NAME   = 3'd2;
    localparam logic [2:0] OP_VSTART = 3'd3;
    localparam logic [2:0] OP_VALUE  = 3'd4;
    localparam logic [2:0] OP_END    = 3'd5;

    // field kinds
    localparam logic [2:0] KIND_TEXT     = 3'd0;
    localparam logic [2:0] KIND_CHECKBOX = 3'd1;
    localparam logic [2:0] KIND_RADIO    = 3'd2;
    localparam logic [2:0] KIND_SUBMIT   = 3'd3;
    localparam logic [2:0] KIND_BUTTON   = 3'd4;

    // characters written into the query
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOW_O   = 8'h6F;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam int unsigned BUDGET_RESET = 2048;

    // one input item
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic [2:0] field_kind;
        logic       field_checked;
        logic       name_empty;
        logic       value_empty;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] byte_count;
        logic        query_done;
        logic        last;
    } t_out_item;

    // encoder state carried from item to item
    typedef struct packed {
        logic [15:0] written_count;
        logic        field_included;
        logic        pair_cut_off;
        logic        query_stopped;
        logic        use_on_default;
    } t_state;

    // results caused by one item, handed to the output serializer
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [15:0]     first_count;
        logic [1:0]      num;
        logic            done;
    } t_group;

    // A-Z a-z 0-9 - _ . ~
    function automatic logic is_unreserved(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
               b == 8'h2E || b == 8'h7E;
    endfunction

    // uppercase hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        if (nib < 4'd10) begin
            return 8'h30 + wide;
        end
        return 8'h37 + wide;
    endfunction

endpackage

// ===== rtl/core/form_query_url_encoder_core.sv =====
// Form query url encoder, top level: input register, encoder state,
// step logic and output serializer. Depends on fqe_pkg, fqe_step, fqe_out.
// Usage
//   Input channel (i_in_valid / o_in_ready, i_in_item) takes form items:
//   begin query, field start, name byte, value start, value byte, end query.
//   Output channel (o_out_valid / i_out_ready, o_out_item) gives encoded
//   query bytes, one per item, with the running byte count; the final item
//   of an end query carries byte 0, the total length and query_done.
//   Config (i_cfg_valid/i_cfg_data, o_cfg_ready tied high) sets the output
//   budget; the user must use it only while the block idles (not enforced).
// Timing
//   An accepted item is registered in the input register, processed by the
//   step logic and loaded into the output serializer once that is free.
//   Each item yields 0 to 3 results and the output sends one result per
//   cycle while the receiver is ready, so an item with several results
//   holds the output until all are sent; items with at most one result
//   flow at one per cycle while the receiver is ready.
// Reset and stall
//   Reset empties both stages, clears the encoder state and sets the budget
//   to 2048. A stalled receiver holds the current result; the input register
//   stays full and o_in_ready drops until the output stage frees up.
module form_query_url_encoder_core
    import fqe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_vld;
    t_in_item    r_in;
    t_state      r_state;
    t_state      n_state;
    logic [15:0] r_budget;
    t_group      step_group;
    logic        out_free;
    logic        advance;
    logic        load;

    // input register hands over when the serializer can take its results
    assign advance    = r_in_vld && out_free;
    assign load       = advance && (step_group.num != 2'd0);
    assign o_in_ready = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // input item payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // encoder state and budget register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_budget <= 16'(BUDGET_RESET);
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end
        end
    end

    fqe_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_budget (r_budget),
        .o_state  (n_state),
        .o_group  (step_group)
    );

    fqe_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_group     (step_group),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/core/fqe_step.sv =====
// next-state and result logic for one registered input item
// depends on fqe_pkg
module fqe_step
    import fqe_pkg::*;
(
    input  t_in_item    i_item,
    input  t_state      i_state,
    input  logic [15:0] i_budget,
    output t_state      o_state,
    output t_group      o_group
);

    logic [16:0] wc_ext;
    logic [16:0] budget_ext;
    logic        fit1;
    logic        fit3;
    logic        fit4;
    logic        fit5;
    logic        active;
    logic        toggle;
    logic        keep_field;
    logic        is_value;
    logic [2:0][7:0] enc_bytes;
    logic [1:0]  enc_num;

    // room checks against the budget
    assign wc_ext     = {1'b0, i_state.written_count};
    assign budget_ext = {1'b0, i_budget};
    assign fit1 = (wc_ext + 17'd1) < budget_ext;
    assign fit3 = (wc_ext + 17'd3) < budget_ext;
    assign fit4 = (wc_ext + 17'd4) < budget_ext;
    assign fit5 = (wc_ext + 17'd5) < budget_ext;

    assign active = i_state.field_included && !i_state.pair_cut_off &&
                    !i_state.query_stopped;
    assign toggle = (i_item.field_kind == KIND_CHECKBOX) ||
                    (i_item.field_kind == KIND_RADIO);
    assign keep_field = !(i_item.field_kind == KIND_SUBMIT ||
                          i_item.field_kind == KIND_BUTTON) &&
                        !(toggle && !i_item.field_checked) && !i_item.name_empty;
    assign is_value = (i_item.op == OP_VALUE);

    // encoding of a name or value byte
    always_comb begin
        enc_bytes = '0;
        enc_num   = 2'd1;
        if (is_value && i_item.data_byte == CH_SPACE) begin
            enc_bytes[0] = CH_PLUS;
        end else if (is_unreserved(i_item.data_byte)) begin
            enc_bytes[0] = i_item.data_byte;
        end else begin
            enc_bytes[0] = CH_PERCENT;
            enc_bytes[1] = hex_char(i_item.data_byte[7:4]);
            enc_bytes[2] = hex_char(i_item.data_byte[3:0]);
            enc_num      = 2'd3;
        end
    end

    // per-op action
    always_comb begin
        o_state = i_state;
        o_group = '0;
        o_group.first_count = i_state.written_count + 16'd1;
        unique case (i_item.op)
            OP_BEGIN: begin
                o_state = '0;
            end
            OP_FIELD: begin
                o_state.field_included = 1'b0;
                o_state.pair_cut_off   = 1'b0;
                o_state.use_on_default = toggle && i_item.value_empty;
                if (keep_field && !i_state.query_stopped) begin
                    if (i_state.written_count != 16'd0 && !fit1) begin
                        o_state.query_stopped = 1'b1;
                    end else begin
                        if (i_state.written_count != 16'd0) begin
                            o_group.bytes[0] = CH_AMP;
                            o_group.num      = 2'd1;
                        end
                        o_state.field_included = 1'b1;
                    end
                end
            end
            OP_NAME, OP_VALUE: begin
                if (active && !(is_value && i_state.use_on_default)) begin
                    if (!fit3) begin
                        o_state.pair_cut_off = 1'b1;
                    end else begin
                        o_group.bytes = enc_bytes;
                        o_group.num   = enc_num;
                    end
                end
            end
            OP_VSTART: begin
                if (active) begin
                    if (!fit1) begin
                        o_state.pair_cut_off = 1'b1;
                    end else begin
                        o_group.bytes[0] = CH_EQ;
                        o_group.num      = 2'd1;
                        if (i_state.use_on_default) begin
                            if (!fit4) begin
                                o_state.pair_cut_off = 1'b1;
                            end else begin
                                o_group.bytes[1] = CH_LOW_O;
                                o_group.num      = 2'd2;
                                if (!fit5) begin
                                    o_state.pair_cut_off = 1'b1;
                                end else begin
                                    o_group.bytes[2] = CH_LOW_N;
                                    o_group.num      = 2'd3;
                                end
                            end
                        end
                    end
                end
            end
            OP_END: begin
                o_group.bytes[0]       = CH_NUL;
                o_group.num            = 2'd1;
                o_group.done           = 1'b1;
                o_group.first_count    = i_state.written_count;
                o_state.query_stopped  = 1'b1;
                o_state.field_included = 1'b0;
            end
            default: begin
            end
        endcase
        // count advances by the bytes written, not by the end marker
        if (!o_group.done) begin
            o_state.written_count = o_state.written_count + {14'd0, o_group.num};
        end
    end

endmodule

// ===== rtl/core/fqe_out.sv =====
// output serializer: holds the results of one item and sends one per cycle while the receiver is ready
// depends on fqe_pkg
module fqe_out
    import fqe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_group    i_group,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic       r_vld;
    logic       n_vld;
    t_group     r_grp;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       at_last;
    logic       pop;

    assign at_last = (r_idx == r_grp.num - 2'd1);
    assign pop     = r_vld && i_out_ready;
    assign o_free  = !r_vld || (pop && at_last);

    // valid and index of the current result
    always_comb begin
        n_vld = r_vld;
        n_idx = r_idx;
        if (i_load) begin
            n_vld = 1'b1;
            n_idx = 2'd0;
        end else if (pop) begin
            if (at_last) begin
                n_vld = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            r_vld <= n_vld;
            r_idx <= n_idx;
        end
    end

    // group payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

    // result fields
    assign o_out_valid           = r_vld;
    assign o_out_item.out_byte   = r_grp.bytes[r_idx];
    assign o_out_item.byte_count = r_grp.done ? r_grp.first_count
                                              : r_grp.first_count + {14'd0, r_idx};
    assign o_out_item.query_done = r_grp.done;
    assign o_out_item.last       = at_last;

endmodule

// ===== rtl/core/fqe_checker.sv =====
// port-level checks for the form query url encoder, bound to the top level
// depends on fqe_pkg and form_query_url_encoder_core
module fqe_checker
    import fqe_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

    // end marker is a zero byte and ends its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.query_done |->
            o_out_item.last && o_out_item.out_byte == CH_NUL)
        else $error("bad end of query result");

    // written bytes carry a nonzero count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.query_done |-> o_out_item.byte_count != 16'd0)
        else $error("zero count on written byte");

    // results of one item follow back to back with counts one apart
    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last |=>
            o_out_valid && o_out_item.byte_count == $past(o_out_item.byte_count) + 16'd1)
        else $error("broken result group");

endmodule

bind form_query_url_encoder_core fqe_checker u_fqe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
